[hw/rtl/mdbs_pkg.sv]
// Shared types and constants for the mecanum drive brake sequencer.
package mdbs_pkg;

	localparam int unsigned SpeedW   = 8;
	localparam int unsigned DutyW    = 8;
	localparam int unsigned ElapsedW = 17;
	localparam int unsigned TicksW   = 16;
	localparam int unsigned Motors   = 4;

	localparam logic [TicksW-1:0] BrakeTicksReset = 16'd100;
	localparam logic signed [SpeedW-1:0] SpeedMax = 8'sd127;
	localparam logic signed [SpeedW-1:0] SpeedMin = -8'sd127;

	typedef enum logic [3:0] {
		ACT_TICK  = 4'd0,
		ACT_FWD   = 4'd1,
		ACT_BACK  = 4'd2,
		ACT_LEFT  = 4'd3,
		ACT_RIGHT = 4'd4,
		ACT_CW    = 4'd5,
		ACT_CCW   = 4'd6,
		ACT_STOP  = 4'd7,
		ACT_BRAKE = 4'd8,
		ACT_SET   = 4'd9
	} action_t;

	typedef logic signed [SpeedW-1:0] speed_t;

	typedef struct packed {
		logic [DutyW-1:0] duty_fl;
		logic [DutyW-1:0] duty_fr;
		logic [DutyW-1:0] duty_bl;
		logic [DutyW-1:0] duty_br;
		logic [3:0]       fwd_mask;
		logic             brake;
	} result_t;

	// Twice the magnitude of a speed held in -127..127.
	function automatic logic [DutyW-1:0] duty_of(input speed_t v);
		logic [SpeedW-1:0] mag;
		begin
			mag = v[SpeedW-1] ? (~v + 8'd1) : v;
			duty_of = {mag[SpeedW-2:0], 1'b0};
		end
	endfunction

endpackage

[hw/rtl/mecanum_drive_brake_sequencer_unit.sv]
// Top level of the mecanum drive brake sequencer: wheel speed state and result stage.
// Each result is registered in the output register, or in the skid slot while the output side stalls.
// Throughput: one item per cycle while in_stall is low; in_stall rises only when the skid slot is full.
// A two-entry result stage (output register plus skid) lets input keep moving
// for one more item while the output side stalls.
// Reset (arst_n low): speeds, queue, brake timer cleared, brake_ticks back to 100.
module mecanum_drive_brake_sequencer_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mdbs_pkg::TicksW-1:0]      cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [3:0]                       action,
	input  logic signed [mdbs_pkg::SpeedW-1:0] speed,
	input  logic [1:0]                       motor_index,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [mdbs_pkg::DutyW-1:0]       duty_front_left,
	output logic [mdbs_pkg::DutyW-1:0]       duty_front_right,
	output logic [mdbs_pkg::DutyW-1:0]       duty_back_left,
	output logic [mdbs_pkg::DutyW-1:0]       duty_back_right,
	output logic [3:0]                       forward_mask,
	output logic                             brake_active
);
	import mdbs_pkg::*;

	// Architectural state
	speed_t              wheel_q [Motors];
	speed_t              pend_q  [Motors];
	logic                brake_q;
	logic                pend_valid_q;
	logic [ElapsedW-1:0] elapsed_q;
	logic [TicksW-1:0]   ticks_q;

	// Result stage
	result_t res_q;
	logic    res_valid_q;
	result_t skid_q;
	logic    skid_valid_q;

	// Next-state values
	speed_t              wheel_n [Motors];
	speed_t              pend_n  [Motors];
	speed_t              pat     [Motors];
	logic                brake_n;
	logic                pend_valid_n;
	logic [ElapsedW-1:0] elapsed_n;
	logic                use_pat;
	logic                queueable;
	speed_t              s;
	result_t             res_n;
	logic                accept;
	logic                take;

	// Stall input only when both result slots are occupied.
	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !skid_valid_q;
	assign take     = res_valid_q && !out_stall;

	// Clamp -128 to -127; everything else is already in range.
	assign s = (speed < SpeedMin) ? SpeedMin : speed;

	always_comb begin
		for (int i = 0; i < Motors; i++) begin
			wheel_n[i] = wheel_q[i];
			pend_n[i]  = pend_q[i];
			pat[i]     = '0;
		end
		brake_n      = brake_q;
		pend_valid_n = pend_valid_q;
		elapsed_n    = elapsed_q;
		use_pat      = 1'b0;
		queueable    = 1'b0;

		unique case (action)
			ACT_TICK: begin
				// Advance the timer, saturating at all ones.
				if (elapsed_q != '1) begin
					elapsed_n = elapsed_q + 1'b1;
				end
			end
			ACT_FWD: begin
				use_pat = 1'b1; queueable = 1'b1;
				pat[0] = s;  pat[1] = s;  pat[2] = s;  pat[3] = s;
			end
			ACT_BACK: begin
				use_pat = 1'b1; queueable = 1'b1;
				pat[0] = -s; pat[1] = -s; pat[2] = -s; pat[3] = -s;
			end
			ACT_LEFT: begin
				use_pat = 1'b1; queueable = 1'b1;
				pat[0] = -s; pat[1] = s;  pat[2] = s;  pat[3] = -s;
			end
			ACT_RIGHT: begin
				use_pat = 1'b1; queueable = 1'b1;
				pat[0] = s;  pat[1] = -s; pat[2] = -s; pat[3] = s;
			end
			ACT_CW: begin
				use_pat = 1'b1;
				pat[0] = s;  pat[1] = -s; pat[2] = s;  pat[3] = -s;
			end
			ACT_CCW: begin
				use_pat = 1'b1;
				pat[0] = -s; pat[1] = s;  pat[2] = -s; pat[3] = s;
			end
			ACT_STOP: begin
				use_pat = 1'b1;
			end
			ACT_BRAKE: begin
				// Reverse every wheel and restart the pulse timer.
				for (int i = 0; i < Motors; i++) begin
					wheel_n[i] = -wheel_q[i];
				end
				elapsed_n = '0;
				brake_n   = 1'b1;
			end
			ACT_SET: begin
				wheel_n[motor_index] = s;
			end
			default: begin
			end
		endcase

		// Translation moves queue behind a running brake; the newest wins.
		if (use_pat) begin
			if (queueable && brake_q) begin
				for (int i = 0; i < Motors; i++) begin
					pend_n[i] = pat[i];
				end
				pend_valid_n = 1'b1;
			end else begin
				for (int i = 0; i < Motors; i++) begin
					wheel_n[i] = pat[i];
				end
			end
		end

		// End of brake pulse: stop the motors, then load any queued move.
		if (brake_n && (elapsed_n > {1'b0, ticks_q})) begin
			brake_n = 1'b0;
			for (int i = 0; i < Motors; i++) begin
				wheel_n[i] = pend_valid_n ? pend_n[i] : '0;
			end
			pend_valid_n = 1'b0;
		end

		res_n.duty_fl = duty_of(wheel_n[0]);
		res_n.duty_fr = duty_of(wheel_n[1]);
		res_n.duty_bl = duty_of(wheel_n[2]);
		res_n.duty_br = duty_of(wheel_n[3]);
		for (int i = 0; i < Motors; i++) begin
			res_n.fwd_mask[i] = (wheel_n[i] > 0);
		end
		res_n.brake = brake_n;
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= BrakeTicksReset;
		end else if (cfg_we) begin
			ticks_q <= cfg_wdata;
		end
	end

	// Commit state on every transfer in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Motors; i++) begin
				wheel_q[i] <= '0;
				pend_q[i]  <= '0;
			end
			brake_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			elapsed_q    <= '0;
		end else if (accept) begin
			for (int i = 0; i < Motors; i++) begin
				wheel_q[i] <= wheel_n[i];
				pend_q[i]  <= pend_n[i];
			end
			brake_q      <= brake_n;
			pend_valid_q <= pend_valid_n;
			elapsed_q    <= elapsed_n;
		end
	end

	// Result register with skid: refill from skid first, else from the new item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!res_valid_q || take) begin
				res_valid_q  <= skid_valid_q || accept;
				skid_valid_q <= 1'b0;
			end else if (accept) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!res_valid_q || take) begin
			res_q <= skid_valid_q ? skid_q : res_n;
		end else if (accept) begin
			skid_q <= res_n;
		end
	end

	assign out_valid        = res_valid_q;
	assign duty_front_left  = res_q.duty_fl;
	assign duty_front_right = res_q.duty_fr;
	assign duty_back_left   = res_q.duty_bl;
	assign duty_back_right  = res_q.duty_br;
	assign forward_mask     = res_q.fwd_mask;
	assign brake_active     = res_q.brake;

	// The skid slot only fills behind an occupied output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> res_valid_q)
		else $error("skid holds a result while output register is empty");

	// A queued move exists only while a brake pulse runs.
	a_pend_needs_brake: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> brake_q)
		else $error("queued move without active brake");

	// The timer only counts up by one or restarts from zero.
	a_timer_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(elapsed_q) |-> (elapsed_q == '0 || elapsed_q == $past(elapsed_q) + 1'b1))
		else $error("brake timer jumped");

endmodule
